[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define MMP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
// Condition that must never be true outside reset.
`define MMP_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define MMP_ASSERT(label, clk, rst_n, prop)
`define MMP_NEVER(label, clk, rst_n, cond)
`endif
`endif

[design/mmp_pkg.sv]
// Types and constants of the modular matrix power block.
`default_nettype none
package mmp_pkg;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned EXP_W  = 63;
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned CNT_W  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic [VAL_W-1:0]  MOD_RESET  = 31'd1000000007;
  localparam logic [VAL_W-1:0]  MOD_MIN    = 31'd2;

  // configuration register indexes
  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_MOD  = 1'b1;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POWER = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] entry_value;
    logic [EXP_W-1:0] exponent;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic [VAL_W-1:0] out_value;
    logic             last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_MUL,
    ST_INIT_WAIT,
    ST_CHECK,
    ST_P_RDA,
    ST_P_RDB,
    ST_P_MUL,
    ST_P_WAIT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // which product is running
  typedef enum logic {
    OP_RES,
    OP_SQ
  } op_e;
endpackage
`default_nettype wire

[design/mmp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module mmp_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[design/modular_matrix_power_top.sv]
// Top level: modular matrix power by square-and-multiply over RAM-held matrices.
`default_nettype none
`include "assert_macros.svh"
// Load beats (kind 0) are taken one per cycle while idle; each writes one
// base entry if its row and column lie below the effective size. A power
// beat (kind 1) stalls the input until the whole result is computed and read out.
// Every modular multiply runs bit-serially in one shared unit, after the
// RAM reads of its multiply-accumulate. An exponent with b significant bits
// and w one bits costs (b + w) matrix products of size n, plus an initial
// reduction pass over the base. The result then leaves row-major, with last
// on the final entry, each beat waiting for the output register to be free.
// A new item can be taken as soon as the last result beat is in the
// output register.
module modular_matrix_power_top #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire mmp_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output mmp_pkg::out_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [mmp_pkg::VAL_W-1:0] cfg_wdata_i
);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VW    = mmp_pkg::VAL_W;
  localparam int unsigned IW    = mmp_pkg::IDX_W;
  localparam int unsigned SW    = mmp_pkg::SIZE_W;

  function automatic logic [AW-1:0] addr_of(logic [IW-1:0] r, logic [IW-1:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // configuration registers
  logic [SW-1:0] size_q;
  logic [VW-1:0] mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mmp_pkg::SIZE_RESET;
      mod_q  <= mmp_pkg::MOD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmp_pkg::CFG_SIZE: size_q <= cfg_wdata_i[SW-1:0];
        mmp_pkg::CFG_MOD:  mod_q  <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  // effective size and modulus
  logic [SW-1:0] eff_n;
  logic [VW-1:0] eff_m;
  always_comb begin
    if (size_q == '0) begin
      eff_n = SW'(1);
    end else if (size_q > SW'(MAX_DIM)) begin
      eff_n = SW'(MAX_DIM);
    end else begin
      eff_n = size_q;
    end
    eff_m = (mod_q < mmp_pkg::MOD_MIN) ? mmp_pkg::MOD_MIN : mod_q;
  end

  // control and datapath registers
  mmp_pkg::state_e           state_q, state_d;
  mmp_pkg::op_e              op_q, op_d;
  logic [IW-1:0]             i_q, i_d, j_q, j_d, k_q, k_d;
  logic [mmp_pkg::EXP_W-1:0] exp_q, exp_d;
  logic [SW-1:0]             n_q, n_d;
  logic [VW-1:0]             m_q, m_d;
  logic [VW-1:0]             sum_q, sum_d;
  logic [VW-1:0]             opa_q, opa_d;
  logic                      out_valid_q, out_valid_d;
  mmp_pkg::out_t             out_q, out_d;

  // bit-serial modular multiplier
  logic                      mbusy_q, mbusy_d;
  logic [VW-1:0]             ma_q, ma_d, mb_q, mb_d, macc_q, macc_d;
  logic [mmp_pkg::CNT_W-1:0] mcnt_q, mcnt_d;
  logic                      mstart;
  logic [VW-1:0]             mstart_a, mstart_b;
  logic [VW+1:0]             mt0, mt1, mt2, m_ext;

  // RAM ports
  logic [AW-1:0] rd_addr, ij_addr, ld_addr;
  logic [VW-1:0] base_rd, sq_rd, res_rd, scr_rd;
  logic          base_we, sq_we, res_we, scr_we;
  logic [VW-1:0] sq_wd, res_wd, scr_wd;

  // loop position helpers
  logic i_last, j_last, k_last, ij_last;
  logic [VW:0] acc_sum;
  logic [VW:0] acc_red;
  logic in_fire;
  logic mul_wait;

  assign i_last  = ({1'b0, i_q} == n_q - SW'(1));
  assign j_last  = ({1'b0, j_q} == n_q - SW'(1));
  assign k_last  = ({1'b0, k_q} == n_q - SW'(1));
  assign ij_last = i_last && j_last;
  assign ij_addr = addr_of(i_q, j_q);
  assign ld_addr = addr_of(in_data_i.row_index, in_data_i.col_index);

  assign in_ready_o  = (state_q == mmp_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mul_wait    = (state_q == mmp_pkg::ST_INIT_WAIT) || (state_q == mmp_pkg::ST_P_WAIT);

  // one double-and-add step, two conditional subtracts keep it below m
  always_comb begin
    m_ext = {2'b00, m_q};
    mt0   = {1'b0, macc_q, 1'b0} + (mb_q[VW-1] ? {2'b00, ma_q} : '0);
    mt1   = (mt0 >= m_ext) ? mt0 - m_ext : mt0;
    mt2   = (mt1 >= m_ext) ? mt1 - m_ext : mt1;
  end

  always_comb begin
    ma_d   = ma_q;
    mb_d   = mb_q;
    macc_d = macc_q;
    mcnt_d = mcnt_q;
    mbusy_d = mbusy_q;
    if (mstart) begin
      ma_d    = mstart_a;
      mb_d    = mstart_b;
      macc_d  = '0;
      mcnt_d  = mmp_pkg::CNT_W'(VW);
      mbusy_d = 1'b1;
    end else if (mbusy_q) begin
      macc_d = mt2[VW-1:0];
      mb_d   = {mb_q[VW-2:0], 1'b0};
      mcnt_d = mcnt_q - mmp_pkg::CNT_W'(1);
      if (mcnt_q == mmp_pkg::CNT_W'(1)) begin
        mbusy_d = 1'b0;
      end
    end
  end

  // dot-product accumulate
  assign acc_sum = {1'b0, sum_q} + {1'b0, macc_q};
  assign acc_red = (acc_sum >= {1'b0, m_q}) ? acc_sum - {1'b0, m_q} : acc_sum;

  // read address per state
  always_comb begin
    unique case (state_q)
      mmp_pkg::ST_P_RDA: rd_addr = addr_of(i_q, k_q);
      mmp_pkg::ST_P_RDB: rd_addr = addr_of(k_q, j_q);
      default:           rd_addr = ij_addr;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    exp_d       = exp_q;
    n_d         = n_q;
    m_d         = m_q;
    sum_d       = sum_q;
    opa_d       = opa_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mstart      = 1'b0;
    mstart_a    = opa_q;
    mstart_b    = sq_rd;
    base_we     = 1'b0;
    sq_we       = 1'b0;
    res_we      = 1'b0;
    scr_we      = 1'b0;
    sq_wd       = macc_q;
    res_wd      = macc_q;
    scr_wd      = acc_red[VW-1:0];

    unique case (state_q)
      mmp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == mmp_pkg::KIND_LOAD) begin
            base_we = ({1'b0, in_data_i.row_index} < eff_n) &&
                      ({1'b0, in_data_i.col_index} < eff_n);
          end else begin
            exp_d   = in_data_i.exponent;
            n_d     = eff_n;
            m_d     = eff_m;
            i_d     = '0;
            j_d     = '0;
            state_d = mmp_pkg::ST_INIT_RD;
          end
        end
      end
      mmp_pkg::ST_INIT_RD: state_d = mmp_pkg::ST_INIT_MUL;
      mmp_pkg::ST_INIT_MUL: begin
        // reduce the base entry as 1 * entry mod m
        mstart   = 1'b1;
        mstart_a = VW'(1);
        mstart_b = base_rd;
        state_d  = mmp_pkg::ST_INIT_WAIT;
      end
      mmp_pkg::ST_INIT_WAIT: begin
        if (!mbusy_q) begin
          sq_we  = 1'b1;
          res_we = 1'b1;
          res_wd = (i_q == j_q) ? VW'(1) : '0;
          j_d    = j_last ? '0 : j_q + IW'(1);
          i_d    = j_last ? i_q + IW'(1) : i_q;
          if (ij_last) begin
            state_d = mmp_pkg::ST_CHECK;
          end else begin
            state_d = mmp_pkg::ST_INIT_RD;
          end
        end
      end
      mmp_pkg::ST_CHECK: begin
        i_d   = '0;
        j_d   = '0;
        k_d   = '0;
        sum_d = '0;
        if (exp_q == '0) begin
          state_d = mmp_pkg::ST_OUT_RD;
        end else begin
          op_d    = exp_q[0] ? mmp_pkg::OP_RES : mmp_pkg::OP_SQ;
          state_d = mmp_pkg::ST_P_RDA;
        end
      end
      mmp_pkg::ST_P_RDA: state_d = mmp_pkg::ST_P_RDB;
      mmp_pkg::ST_P_RDB: begin
        // left operand arrives now
        opa_d   = (op_q == mmp_pkg::OP_RES) ? res_rd : sq_rd;
        state_d = mmp_pkg::ST_P_MUL;
      end
      mmp_pkg::ST_P_MUL: begin
        mstart  = 1'b1;
        state_d = mmp_pkg::ST_P_WAIT;
      end
      mmp_pkg::ST_P_WAIT: begin
        if (!mbusy_q) begin
          if (k_last) begin
            scr_we = 1'b1;
            sum_d  = '0;
            k_d    = '0;
            j_d    = j_last ? '0 : j_q + IW'(1);
            // back to the top-left entry after the last one
            i_d    = ij_last ? '0 : (j_last ? i_q + IW'(1) : i_q);
            state_d = ij_last ? mmp_pkg::ST_COPY_RD : mmp_pkg::ST_P_RDA;
          end else begin
            sum_d   = acc_red[VW-1:0];
            k_d     = k_q + IW'(1);
            state_d = mmp_pkg::ST_P_RDA;
          end
        end
      end
      mmp_pkg::ST_COPY_RD: state_d = mmp_pkg::ST_COPY_WR;
      mmp_pkg::ST_COPY_WR: begin
        sq_wd  = scr_rd;
        res_wd = scr_rd;
        if (op_q == mmp_pkg::OP_RES) begin
          res_we = 1'b1;
        end else begin
          sq_we = 1'b1;
        end
        j_d = j_last ? '0 : j_q + IW'(1);
        i_d = ij_last ? '0 : (j_last ? i_q + IW'(1) : i_q);
        if (ij_last) begin
          if (op_q == mmp_pkg::OP_RES) begin
            op_d    = mmp_pkg::OP_SQ;
            state_d = mmp_pkg::ST_P_RDA;
          end else begin
            exp_d   = exp_q >> 1;
            state_d = mmp_pkg::ST_CHECK;
          end
        end else begin
          state_d = mmp_pkg::ST_COPY_RD;
        end
      end
      mmp_pkg::ST_OUT_RD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = mmp_pkg::ST_OUT_LD;
        end
      end
      mmp_pkg::ST_OUT_LD: begin
        out_valid_d       = 1'b1;
        out_d.out_row     = i_q;
        out_d.out_col     = j_q;
        out_d.out_value   = res_rd;
        out_d.last        = ij_last;
        j_d = j_last ? '0 : j_q + IW'(1);
        i_d = j_last ? i_q + IW'(1) : i_q;
        state_d = ij_last ? mmp_pkg::ST_IDLE : mmp_pkg::ST_OUT_RD;
      end
      default: state_d = mmp_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmp_pkg::ST_IDLE;
      op_q        <= mmp_pkg::OP_RES;
      out_valid_q <= 1'b0;
      mbusy_q     <= 1'b0;
      mcnt_q      <= '0;
      exp_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      mbusy_q     <= mbusy_d;
      mcnt_q      <= mcnt_d;
      exp_q       <= exp_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    m_q    <= m_d;
    sum_q  <= sum_d;
    opa_q  <= opa_d;
    out_q  <= out_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    macc_q <= macc_d;
  end

  // matrix stores
  mmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_base_ram (
    .clk_i(clk_i), .we_i(base_we), .waddr_i(ld_addr),
    .wdata_i(in_data_i.entry_value), .raddr_i(rd_addr), .rdata_o(base_rd)
  );
  mmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_sq_ram (
    .clk_i(clk_i), .we_i(sq_we), .waddr_i(ij_addr),
    .wdata_i(sq_wd), .raddr_i(rd_addr), .rdata_o(sq_rd)
  );
  mmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_res_ram (
    .clk_i(clk_i), .we_i(res_we), .waddr_i(ij_addr),
    .wdata_i(res_wd), .raddr_i(rd_addr), .rdata_o(res_rd)
  );
  mmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_scr_ram (
    .clk_i(clk_i), .we_i(scr_we), .waddr_i(ij_addr),
    .wdata_i(scr_wd), .raddr_i(rd_addr), .rdata_o(scr_rd)
  );

  // checks
  `MMP_ASSERT(a_mul_only_waited, clk_i, rst_ni, mbusy_q |-> mul_wait)
  `MMP_ASSERT(a_last_diag, clk_i, rst_ni, (out_valid_q && out_q.last) |-> (out_q.out_row == out_q.out_col))
  `MMP_NEVER(a_load_in_busy, clk_i, rst_ni, (base_we && state_q != mmp_pkg::ST_IDLE))
  `MMP_ASSERT(a_mul_below_mod, clk_i, rst_ni, (mul_wait && !mbusy_q) |-> (macc_q < m_q))

endmodule
`default_nettype wire
